@@ hdl/vgsr_pkg.sv @@
// ----------------------------------------------------------------------------
// vgsr_pkg
// Shared types and constants of the voxel grid shape rasterizer.
// ----------------------------------------------------------------------------
package vgsr_pkg;

    localparam int CRD_W  = 8;
    localparam int HI_W   = 9;
    localparam int SQ_W   = 16;
    localparam int COEF_W = 20;
    localparam int RHS_W  = 30;
    localparam int PROD_W = 36;
    localparam int SUM_W  = 38;
    localparam int COL_W  = 32;

    localparam logic [3:0] FN_SET_BOX = 4'd0;
    localparam logic [3:0] FN_CLR_BOX = 4'd1;
    localparam logic [3:0] FN_SET_SPH = 4'd2;
    localparam logic [3:0] FN_CLR_SPH = 4'd3;
    localparam logic [3:0] FN_SET_ELL = 4'd4;
    localparam logic [3:0] FN_CLR_ELL = 4'd5;
    localparam logic [3:0] FN_SET_VOX = 4'd6;
    localparam logic [3:0] FN_CLR_VOX = 4'd7;
    localparam logic [3:0] FN_READ    = 4'd8;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_SCAN = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;
    localparam logic [1:0] REG_ALPHA = 2'd3;

    typedef struct packed {
        logic [3:0] func;
        logic [4:0] ax;
        logic [4:0] ay;
        logic [4:0] az;
        logic [5:0] bx;
        logic [5:0] by;
        logic [5:0] bz;
        logic [5:0] radius;
        logic [4:0] rad_x;
        logic [4:0] rad_y;
        logic [4:0] rad_z;
    } cmd_in_t;

    typedef struct packed {
        logic       voxel_shown;
        logic [7:0] voxel_red;
        logic [7:0] voxel_green;
        logic [7:0] voxel_blue;
        logic [7:0] voxel_alpha;
    } res_t;

    typedef struct packed {
        logic [1:0]        op;
        logic              set;
        logic              shape;
        logic [CRD_W-1:0]  lo_x;
        logic [CRD_W-1:0]  lo_y;
        logic [CRD_W-1:0]  lo_z;
        logic [HI_W-1:0]   hi_x;
        logic [HI_W-1:0]   hi_y;
        logic [HI_W-1:0]   hi_z;
        logic [4:0]        c_x;
        logic [4:0]        c_y;
        logic [4:0]        c_z;
        logic [COEF_W-1:0] k_x;
        logic [COEF_W-1:0] k_y;
        logic [COEF_W-1:0] k_z;
        logic [RHS_W-1:0]  rhs;
    } cmd_t;

endpackage

@@ hdl/voxel_grid_shape_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_shape_rasterizer_core
// Voxel store with box, sphere, ellipsoid and single voxel edits and reads.
// ----------------------------------------------------------------------------
// After reset the store is swept clear, one entry per cycle, over all
// 2^(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z)) entries (32768 by default);
// full stays high during the sweep. A command passes the front stage's
// squaring, multiply, right-hand-side and push states and then takes one queue
// slot. The back end tests one voxel per cycle: a sphere or ellipsoid scans
// the whole grid and a box its clipped volume. Every command yields exactly one
// result; only a read of a voxel inside the grid returns nonzero data.
module voxel_grid_shape_rasterizer_core #(
    parameter int SIZE_X = 32,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  vgsr_pkg::cmd_in_t cmd,
    output logic              empty,
    input  logic              pop,
    output vgsr_pkg::res_t    res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import vgsr_pkg::*;

    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic       clr_busy;
    logic       q_push, q_full, q_pop, q_empty;
    cmd_t       q_wdata, q_rdata;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= 8'd0;
            green_reg <= 8'd0;
            blue_reg  <= 8'd0;
            alpha_reg <= 8'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_RED:   red_reg   <= pwdata[7:0];
                REG_GREEN: green_reg <= pwdata[7:0];
                REG_BLUE:  blue_reg  <= pwdata[7:0];
                REG_ALPHA: alpha_reg <= pwdata[7:0];
                default:   red_reg   <= red_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RED:   prdata = {24'd0, red_reg};
            REG_GREEN: prdata = {24'd0, green_reg};
            REG_BLUE:  prdata = {24'd0, blue_reg};
            REG_ALPHA: prdata = {24'd0, alpha_reg};
            default:   prdata = 32'd0;
        endcase
    end

    vgsr_front #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .hold   (clr_busy),
        .push   (push),
        .full   (full),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    vgsr_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (q_wdata),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    vgsr_back #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr_busy (clr_busy),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_rdata),
        .paint    ({red_reg, green_reg, blue_reg, alpha_reg}),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

endmodule

@@ hdl/vgsr_front.sv @@
// ----------------------------------------------------------------------------
// vgsr_front
// Accepts commands, classifies them and works out scan bounds and test terms.
// ----------------------------------------------------------------------------
module vgsr_front #(
    parameter int SIZE_X = 32,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            hold,
    input  logic            push,
    output logic            full,
    input  vgsr_pkg::cmd_in_t cmd,
    input  logic            q_full,
    output logic            q_push,
    output vgsr_pkg::cmd_t  q_data
);
    import vgsr_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_SQ   = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_RHS  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    localparam logic [HI_W-1:0] LIM_X = HI_W'(SIZE_X);
    localparam logic [HI_W-1:0] LIM_Y = HI_W'(SIZE_Y);
    localparam logic [HI_W-1:0] LIM_Z = HI_W'(SIZE_Z);

    logic [2:0]        state_reg, state_next;
    cmd_in_t           in_reg;
    logic [9:0]        x2_reg, y2_reg, z2_reg;
    logic [13:0]       sph_reg;
    logic [COEF_W-1:0] kx_reg, ky_reg, kz_reg;
    logic [RHS_W-1:0]  rhs_reg;
    logic [6:0]        r1;
    logic [HI_W-1:0]   ax_e, ay_e, az_e;
    logic [HI_W-1:0]   bx_c, by_c, bz_c;
    logic [HI_W-1:0]   vx_c, vy_c, vz_c;
    cmd_t              c;

    assign full = hold || (state_reg != F_IDLE);
    assign q_push = (state_reg == F_PUSH) && !q_full;
    assign r1 = 7'(in_reg.radius) + 7'd1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (push && !full) state_next = F_SQ;
            F_SQ:    state_next = F_MUL;
            F_MUL:   state_next = F_RHS;
            F_RHS:   state_next = F_PUSH;
            F_PUSH:  if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push && !full)
        begin
            in_reg <= cmd;
        end
        if (state_reg == F_SQ)
        begin
            x2_reg  <= 10'(in_reg.rad_x) * 10'(in_reg.rad_x);
            y2_reg  <= 10'(in_reg.rad_y) * 10'(in_reg.rad_y);
            z2_reg  <= 10'(in_reg.rad_z) * 10'(in_reg.rad_z);
            sph_reg <= 14'(r1) * 14'(r1);
        end
        if (state_reg == F_MUL)
        begin
            kx_reg <= COEF_W'(y2_reg) * COEF_W'(z2_reg);
            ky_reg <= COEF_W'(x2_reg) * COEF_W'(z2_reg);
            kz_reg <= COEF_W'(x2_reg) * COEF_W'(y2_reg);
        end
        if (state_reg == F_RHS)
        begin
            rhs_reg <= RHS_W'(kx_reg) * RHS_W'(x2_reg);
        end
    end

    assign ax_e = HI_W'(in_reg.ax);
    assign ay_e = HI_W'(in_reg.ay);
    assign az_e = HI_W'(in_reg.az);
    assign bx_c = (HI_W'(in_reg.bx) < LIM_X) ? HI_W'(in_reg.bx) : LIM_X;
    assign by_c = (HI_W'(in_reg.by) < LIM_Y) ? HI_W'(in_reg.by) : LIM_Y;
    assign bz_c = (HI_W'(in_reg.bz) < LIM_Z) ? HI_W'(in_reg.bz) : LIM_Z;
    assign vx_c = (ax_e + HI_W'(1) < LIM_X) ? ax_e + HI_W'(1) : LIM_X;
    assign vy_c = (ay_e + HI_W'(1) < LIM_Y) ? ay_e + HI_W'(1) : LIM_Y;
    assign vz_c = (az_e + HI_W'(1) < LIM_Z) ? az_e + HI_W'(1) : LIM_Z;

    always_comb
    begin
        c       = '0;
        c.set   = ~in_reg.func[0];
        c.c_x   = in_reg.ax;
        c.c_y   = in_reg.ay;
        c.c_z   = in_reg.az;
        c.lo_x  = CRD_W'(in_reg.ax);
        c.lo_y  = CRD_W'(in_reg.ay);
        c.lo_z  = CRD_W'(in_reg.az);
        unique case (in_reg.func)
            FN_SET_BOX, FN_CLR_BOX:
            begin
                c.hi_x = bx_c;
                c.hi_y = by_c;
                c.hi_z = bz_c;
                c.op = (bx_c > ax_e && by_c > ay_e && bz_c > az_e) ? OP_SCAN : OP_NONE;
            end
            FN_SET_VOX, FN_CLR_VOX:
            begin
                c.hi_x = vx_c;
                c.hi_y = vy_c;
                c.hi_z = vz_c;
                c.op = (vx_c > ax_e && vy_c > ay_e && vz_c > az_e) ? OP_SCAN : OP_NONE;
            end
            FN_SET_SPH, FN_CLR_SPH:
            begin
                c.op    = OP_SCAN;
                c.shape = 1'b1;
                c.lo_x  = '0;
                c.lo_y  = '0;
                c.lo_z  = '0;
                c.hi_x  = LIM_X;
                c.hi_y  = LIM_Y;
                c.hi_z  = LIM_Z;
                c.k_x   = COEF_W'(1);
                c.k_y   = COEF_W'(1);
                c.k_z   = COEF_W'(1);
                c.rhs   = RHS_W'(sph_reg);
            end
            FN_SET_ELL, FN_CLR_ELL:
            begin
                c.op    = OP_SCAN;
                c.shape = 1'b1;
                c.lo_x  = '0;
                c.lo_y  = '0;
                c.lo_z  = '0;
                c.hi_x  = LIM_X;
                c.hi_y  = LIM_Y;
                c.hi_z  = LIM_Z;
                c.k_x   = kx_reg;
                c.k_y   = ky_reg;
                c.k_z   = kz_reg;
                c.rhs   = rhs_reg;
            end
            FN_READ:
            begin
                c.op = (ax_e < LIM_X && ay_e < LIM_Y && az_e < LIM_Z) ? OP_READ : OP_NONE;
            end
            default:
            begin
                c.op = OP_NONE;
            end
        endcase
    end

    assign q_data = c;

endmodule

@@ hdl/vgsr_cmdq.sv @@
// ----------------------------------------------------------------------------
// vgsr_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module vgsr_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  vgsr_pkg::cmd_t wdata,
    input  logic           pop,
    output logic           empty,
    output vgsr_pkg::cmd_t rdata
);
    import vgsr_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rdata   = slot_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push) wp_reg <= ~wp_reg;
            if (do_pop)  rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

endmodule

@@ hdl/vgsr_back.sv @@
// ----------------------------------------------------------------------------
// vgsr_back
// Clears the voxel store after reset, scans shapes through a three-stage
// test pipeline, serves reads and queues results.
// ----------------------------------------------------------------------------
module vgsr_back #(
    parameter int SIZE_X = 32,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    clr_busy,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  vgsr_pkg::cmd_t          q_data,
    input  logic [vgsr_pkg::COL_W-1:0] paint,
    output logic                    empty,
    input  logic                    pop,
    output vgsr_pkg::res_t          res
);
    import vgsr_pkg::*;

    localparam int XW    = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int YW    = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
    localparam int ZW    = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int AW    = XW + YW + ZW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] B_CLR   = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_SCAN  = 3'd2;
    localparam logic [2:0] B_DRAIN = 3'd3;
    localparam logic [2:0] B_RD    = 3'd4;
    localparam logic [2:0] B_RDW   = 3'd5;
    localparam logic [2:0] B_RES   = 3'd6;

    logic             shown_mem [DEPTH];
    logic [COL_W-1:0] col_mem   [DEPTH];

    logic [2:0]       state_reg, state_next;
    cmd_t             cur_reg;
    logic [CRD_W-1:0] x_reg, y_reg, z_reg;
    logic [CRD_W-1:0] x_next, y_next, z_next;
    logic [AW-1:0]    clr_reg;
    logic             v1_reg, v2_reg;
    logic [AW-1:0]    a1_reg, a2_reg;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic [PROD_W-1:0] px_reg, py_reg, pz_reg;
    logic             rd_shown_reg;
    logic [COL_W-1:0] rd_col_reg;
    res_t             res_reg;
    res_t             ob_reg [2];
    logic             owp_reg, orp_reg;
    logic [1:0]       ocnt_reg;

    logic [CRD_W-1:0] cx, cy, cz, dx, dy, dz;
    logic [HI_W-1:0]  x1, y1, z1;
    logic             z_wrap, y_wrap, last;
    logic [AW-1:0]    scan_addr, rd_addr, mem_addr;
    logic [SUM_W-1:0] sum;
    logic             hit, mem_we, col_we, mem_shown;
    logic [COL_W-1:0] mem_col;
    logic             o_full, o_push, o_pop;

    assign clr_busy = (state_reg == B_CLR);

    assign cx = CRD_W'(cur_reg.c_x);
    assign cy = CRD_W'(cur_reg.c_y);
    assign cz = CRD_W'(cur_reg.c_z);
    assign dx = (x_reg >= cx) ? x_reg - cx : cx - x_reg;
    assign dy = (y_reg >= cy) ? y_reg - cy : cy - y_reg;
    assign dz = (z_reg >= cz) ? z_reg - cz : cz - z_reg;

    assign x1     = HI_W'(x_reg) + HI_W'(1);
    assign y1     = HI_W'(y_reg) + HI_W'(1);
    assign z1     = HI_W'(z_reg) + HI_W'(1);
    assign z_wrap = (z1 == cur_reg.hi_z);
    assign y_wrap = (y1 == cur_reg.hi_y);
    assign last   = z_wrap && y_wrap && (x1 == cur_reg.hi_x);

    assign scan_addr = {x_reg[XW-1:0], y_reg[YW-1:0], z_reg[ZW-1:0]};
    assign rd_addr   = {cur_reg.lo_x[XW-1:0], cur_reg.lo_y[YW-1:0], cur_reg.lo_z[ZW-1:0]};

    assign sum = SUM_W'(px_reg) + SUM_W'(py_reg) + SUM_W'(pz_reg);
    assign hit = ~cur_reg.shape || (sum < SUM_W'(cur_reg.rhs));

    assign mem_we    = clr_busy || (v2_reg && hit);
    assign col_we    = clr_busy || (v2_reg && hit && cur_reg.set);
    assign mem_addr  = clr_busy ? clr_reg : a2_reg;
    assign mem_shown = clr_busy ? 1'b0 : cur_reg.set;
    assign mem_col   = clr_busy ? '0 : paint;

    assign o_full = (ocnt_reg == 2'd2);
    assign empty  = (ocnt_reg == 2'd0);
    assign res    = ob_reg[orp_reg];
    assign o_push = (state_reg == B_RES) && !o_full;
    assign o_pop  = pop && !empty;
    assign q_pop  = (state_reg == B_IDLE) && !q_empty;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (state_reg == B_IDLE)
        begin
            x_next = q_data.lo_x;
            y_next = q_data.lo_y;
            z_next = q_data.lo_z;
        end
        else if (state_reg == B_SCAN)
        begin
            if (!z_wrap)
            begin
                z_next = CRD_W'(z1);
            end
            else
            begin
                z_next = cur_reg.lo_z;
                if (!y_wrap)
                begin
                    y_next = CRD_W'(y1);
                end
                else
                begin
                    y_next = cur_reg.lo_y;
                    x_next = CRD_W'(x1);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLR:
                if (clr_reg == AW'(DEPTH - 1)) state_next = B_IDLE;
            B_IDLE:
                if (!q_empty)
                begin
                    unique case (q_data.op)
                        OP_SCAN: state_next = B_SCAN;
                        OP_READ: state_next = B_RD;
                        default: state_next = B_RES;
                    endcase
                end
            B_SCAN:
                if (last) state_next = B_DRAIN;
            B_DRAIN:
                if (!v1_reg && !v2_reg) state_next = B_RES;
            B_RD:
                state_next = B_RDW;
            B_RDW:
                state_next = B_RES;
            B_RES:
                if (!o_full) state_next = B_IDLE;
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            owp_reg   <= 1'b0;
            orp_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy) clr_reg <= clr_reg + AW'(1);
            v1_reg <= (state_reg == B_SCAN);
            v2_reg <= v1_reg;
            if (o_push) owp_reg <= ~owp_reg;
            if (o_pop)  orp_reg <= ~orp_reg;
            if (o_push && !o_pop)
            begin
                ocnt_reg <= ocnt_reg + 2'd1;
            end
            else if (o_pop && !o_push)
            begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
            res_reg <= '0;
        end
        if (state_reg == B_RDW)
        begin
            res_reg <= {rd_shown_reg, rd_col_reg};
        end
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
        a1_reg <= scan_addr;
        sx_reg <= SQ_W'(dx) * SQ_W'(dx);
        sy_reg <= SQ_W'(dy) * SQ_W'(dy);
        sz_reg <= SQ_W'(dz) * SQ_W'(dz);
        a2_reg <= a1_reg;
        px_reg <= PROD_W'(sx_reg) * PROD_W'(cur_reg.k_x);
        py_reg <= PROD_W'(sy_reg) * PROD_W'(cur_reg.k_y);
        pz_reg <= PROD_W'(sz_reg) * PROD_W'(cur_reg.k_z);
        if (o_push)
        begin
            ob_reg[owp_reg] <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shown_mem[mem_addr] <= mem_shown;
        end
        if (col_we)
        begin
            col_mem[mem_addr] <= mem_col;
        end
        rd_shown_reg <= shown_mem[rd_addr];
        rd_col_reg   <= col_mem[rd_addr];
    end

endmodule

@@ hdl/vgsr_chk.sv @@
// ----------------------------------------------------------------------------
// vgsr_chk
// Port-level checks of the voxel grid shape rasterizer, bound to the core.
// ----------------------------------------------------------------------------
module vgsr_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           push,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input vgsr_pkg::res_t res,
    input logic           pready
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("full low right after an accepted transaction");

    a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full)
        else $error("input open before the store sweep");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res)))
        else $error("waiting result changed or dropped");

    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind voxel_grid_shape_rasterizer_core vgsr_chk u_vgsr_chk (.*);

@@ tb/tb_voxel_grid_shape_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_voxel_grid_shape_rasterizer_core
// Self-checking bench for the voxel store: commands are driven through the
// push/full queue, every result is matched against a voxel model kept in the
// bench, and the paint colour is changed over APB between traffic phases.
// ----------------------------------------------------------------------------
module tb_voxel_grid_shape_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vgsr_pkg::*;

    localparam int GRID = 32;
    localparam int VOXELS = GRID * GRID * GRID;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    cmd_in_t     cmd = '0;
    logic        empty;
    logic        pop = 1'b0;
    res_t        res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    voxel_grid_shape_rasterizer_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd),
        .empty(empty), .pop(pop), .res(res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    bit       shown_mem [VOXELS];
    bit [7:0] color_mem [VOXELS][4];
    bit [7:0] paint [4];

    cmd_in_t cmd_backlog[$];
    res_t    pending_results[$];
    int      send_wait = 0;
    int      pop_wait = 0;
    bit      send_burst = 0;
    bit      pop_burst = 0;
    int      n_fail = 0;
    int      n_cmds = 0;
    int      n_reads = 0;
    int      n_shapes = 0;
    int      n_shown = 0;
    int      hot_x = 16;
    int      hot_y = 16;
    int      hot_z = 16;

    initial forever #5 clk = ~clk;

    function automatic void touch_voxel(int x, int y, int z, bit set);
        int n;
        n = (x * GRID + y) * GRID + z;
        if (x >= GRID || y >= GRID || z >= GRID)
            return;
        shown_mem[n] = set;
        if (set)
            color_mem[n] = paint;
    endfunction

    function automatic longint sq(int a, int b);
        longint d;
        d = a - b;
        return d * d;
    endfunction

    function automatic res_t rasterize_command(cmd_in_t c);
        res_t   r;
        bit     set;
        int     hx, hy, hz, n;
        longint lim, x2, y2, z2, rhs, lhs;
        r = '0;
        set = ~c.func[0];
        x2 = c.rad_x * c.rad_x;
        y2 = c.rad_y * c.rad_y;
        z2 = c.rad_z * c.rad_z;
        rhs = x2 * y2 * z2;
        lim = (c.radius + 1) * (c.radius + 1);
        hx = c.bx < GRID ? c.bx : GRID;
        hy = c.by < GRID ? c.by : GRID;
        hz = c.bz < GRID ? c.bz : GRID;
        case (c.func)
            FN_SET_BOX, FN_CLR_BOX:
                for (int i = c.ax; i < hx; i++)
                    for (int j = c.ay; j < hy; j++)
                        for (int k = c.az; k < hz; k++)
                            touch_voxel(i, j, k, set);
            FN_SET_SPH, FN_CLR_SPH:
                for (int i = 0; i < GRID; i++)
                    for (int j = 0; j < GRID; j++)
                        for (int k = 0; k < GRID; k++)
                            if (sq(i, c.ax) + sq(j, c.ay) + sq(k, c.az) < lim)
                                touch_voxel(i, j, k, set);
            FN_SET_ELL, FN_CLR_ELL:
                for (int i = 0; i < GRID; i++)
                    for (int j = 0; j < GRID; j++)
                        for (int k = 0; k < GRID; k++)
                        begin
                            lhs = sq(i, c.ax) * y2 * z2 + sq(j, c.ay) * x2 * z2
                                + sq(k, c.az) * x2 * y2;
                            if (lhs < rhs)
                                touch_voxel(i, j, k, set);
                        end
            FN_SET_VOX, FN_CLR_VOX:
                touch_voxel(c.ax, c.ay, c.az, set);
            FN_READ:
            begin
                n = (c.ax * GRID + c.ay) * GRID + c.az;
                r.voxel_shown = shown_mem[n];
                r.voxel_red   = color_mem[n][0];
                r.voxel_green = color_mem[n][1];
                r.voxel_blue  = color_mem[n][2];
                r.voxel_alpha = color_mem[n][3];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 13);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            pending_results.push_back(rasterize_command(cmd));
            n_cmds++;
            if (cmd.func == FN_READ)
                n_reads++;
            if (cmd.func inside {[FN_SET_SPH:FN_CLR_ELL]})
                n_shapes++;
            if ($urandom_range(0, 19) == 0)
                send_burst = ~send_burst;
            send_wait = draw_gap(send_burst);
        end
        if (!push || !full)
        begin
            if (rst_n && send_wait == 0 && cmd_backlog.size() > 0)
            begin
                push <= 1'b1;
                cmd <= cmd_backlog.pop_front();
            end
            else
            begin
                push <= 1'b0;
                if (send_wait > 0)
                    send_wait--;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, res);
                n_fail++;
            end
            else
            begin
                res_t e;
                e = pending_results.pop_front();
                if (res.voxel_shown !== e.voxel_shown)
                    $display("%0t: voxel_shown expected %h actual %h",
                             $time, e.voxel_shown, res.voxel_shown);
                if (res.voxel_red !== e.voxel_red)
                    $display("%0t: voxel_red expected %h actual %h",
                             $time, e.voxel_red, res.voxel_red);
                if (res.voxel_green !== e.voxel_green)
                    $display("%0t: voxel_green expected %h actual %h",
                             $time, e.voxel_green, res.voxel_green);
                if (res.voxel_blue !== e.voxel_blue)
                    $display("%0t: voxel_blue expected %h actual %h",
                             $time, e.voxel_blue, res.voxel_blue);
                if (res.voxel_alpha !== e.voxel_alpha)
                    $display("%0t: voxel_alpha expected %h actual %h",
                             $time, e.voxel_alpha, res.voxel_alpha);
                if (res !== e)
                    n_fail++;
                if (e.voxel_shown)
                    n_shown++;
            end
            if ($urandom_range(0, 19) == 0)
                pop_burst = ~pop_burst;
            pop_wait = draw_gap(pop_burst);
        end
        else if (pop_wait > 0)
            pop_wait--;
        pop <= rst_n && (pop_wait == 0 || (pop && !empty && pop_wait == 0));
    end

    task automatic drain();
        while (cmd_backlog.size() > 0 || push || pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_paint(logic [1:0] idx, logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'($urandom_range(0, 16777215)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        paint[idx] = pwdata[7:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_paint(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic [7:0] a);
        drain();
        write_paint(REG_RED, r);
        write_paint(REG_GREEN, g);
        write_paint(REG_BLUE, b);
        write_paint(REG_ALPHA, a);
    endtask

    function automatic cmd_in_t make_cmd(logic [3:0] f, int x, int y, int z);
        cmd_in_t c;
        c = '0;
        c.func = f;
        c.ax = 5'(x);
        c.ay = 5'(y);
        c.az = 5'(z);
        return c;
    endfunction

    function automatic cmd_in_t random_cmd();
        cmd_in_t c;
        int      pick;
        c = cmd_in_t'(58'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            c.func = FN_READ;
            c.ax = 5'(hot_x + $urandom_range(0, 4) - 2);
            c.ay = 5'(hot_y + $urandom_range(0, 4) - 2);
            c.az = 5'(hot_z + $urandom_range(0, 4) - 2);
        end
        else if (pick < 60)
        begin
            c.func = $urandom_range(0, 3) == 0 ? FN_CLR_VOX : FN_SET_VOX;
            c.ax = 5'(hot_x + $urandom_range(0, 2) - 1);
            c.ay = 5'(hot_y + $urandom_range(0, 2) - 1);
            c.az = 5'(hot_z + $urandom_range(0, 2) - 1);
        end
        else if (pick < 86)
        begin
            c.func = $urandom_range(0, 3) == 0 ? FN_CLR_BOX : FN_SET_BOX;
            c.bx = 6'(c.ax + $urandom_range(0, 4));
            c.by = 6'(c.ay + $urandom_range(0, 4));
            c.bz = 6'(c.az + $urandom_range(0, 4));
            if (pick > 82)
            begin
                c.ax = 5'($urandom_range(28, 31));
                c.bx = 6'($urandom_range(32, 63));
            end
        end
        else if (pick < 93)
        begin
            c.func = 4'($urandom_range(FN_SET_SPH, FN_CLR_ELL));
            c.radius = 6'($urandom_range(0, 12));
            if (pick == 92)
                c.radius = 6'($urandom_range(0, 63));
        end
        else
            c.func = 4'($urandom_range(9, 15));
        if (c.func != FN_READ)
        begin
            hot_x = c.ax;
            hot_y = c.ay;
            hot_z = c.az;
        end
        return c;
    endfunction

    initial
    begin
        cmd_in_t c;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_paint(8'h12, 8'h34, 8'h56, 8'h78);
        cmd_backlog.push_back(make_cmd(FN_READ, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(FN_SET_VOX, 31, 31, 31));
        cmd_backlog.push_back(make_cmd(FN_READ, 31, 31, 31));
        c = make_cmd(FN_SET_BOX, 0, 0, 0);
        c.bx = 6'd32; c.by = 6'd32; c.bz = 6'd32;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 5, 6, 7));
        c = make_cmd(FN_CLR_BOX, 10, 0, 0);
        c.bx = 6'd63; c.by = 6'd63; c.bz = 6'd63;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 31, 0, 0));
        c = make_cmd(FN_CLR_BOX, 3, 3, 3);
        c.bx = 6'd3; c.by = 6'd9; c.bz = 6'd9;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 3, 3, 3));
        c = make_cmd(FN_CLR_SPH, 5, 16, 16);
        c.radius = 6'd3;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 5, 16, 19));
        cmd_backlog.push_back(make_cmd(FN_READ, 5, 16, 20));
        c = make_cmd(FN_CLR_SPH, 0, 0, 0);
        c.radius = 6'd63;
        cmd_backlog.push_back(c);
        c = make_cmd(FN_SET_SPH, 20, 20, 20);
        c.radius = 6'd0;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 20, 20, 20));
        c = make_cmd(FN_SET_ELL, 16, 16, 16);
        c.rad_x = 5'd4; c.rad_y = 5'd2; c.rad_z = 5'd31;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 19, 16, 16));
        cmd_backlog.push_back(make_cmd(FN_READ, 20, 16, 16));
        c = make_cmd(FN_CLR_ELL, 16, 16, 16);
        c.rad_x = 5'd0; c.rad_y = 5'd31; c.rad_z = 5'd31;
        cmd_backlog.push_back(c);
        c = make_cmd(FN_CLR_ELL, 16, 16, 16);
        c.rad_x = 5'd1; c.rad_y = 5'd1; c.rad_z = 5'd1;
        cmd_backlog.push_back(c);
        cmd_backlog.push_back(make_cmd(FN_READ, 16, 16, 16));
        cmd_backlog.push_back(make_cmd(FN_CLR_VOX, 31, 31, 31));
        cmd_backlog.push_back(cmd_in_t'({4'd9, {54{1'b1}}}));
        cmd_backlog.push_back(make_cmd(4'd15, 31, 31, 31));
        cmd_backlog.push_back(make_cmd(FN_READ, 31, 31, 31));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: set_paint(8'hff, 8'hff, 8'hff, 8'hff);
                1: set_paint(8'h00, 8'h00, 8'h00, 8'h00);
                2: set_paint(8'h80, 8'h01, 8'hfe, 8'h7f);
                default: set_paint(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom));
            endcase
            for (int i = 0; i < 19; i++)
                cmd_backlog.push_back(random_cmd());
        end
        drain();

        $display("Ran %0d commands: %0d reads (%0d visible), %0d sphere/ellipsoid scans,",
                 n_cmds, n_reads, n_shown, n_shapes);
        $display("with the paint colour rewritten over APB in 5 settings.");
        if (n_fail == 0)
            $display("tb_voxel_grid_shape_rasterizer_core passed");
        else
            $display("tb_voxel_grid_shape_rasterizer_core failed");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("tb_voxel_grid_shape_rasterizer_core failed");
        $finish;
    end

endmodule
